FILE: rtl/rqs_pkg.sv
package rqs_pkg;

  // Sizing
  localparam int MAX_THREADS = 16;
  localparam int SLEEP_WIDTH = 16;
  localparam int ID_W        = 4;
  localparam int TICKS_W     = 16;
  localparam int WOKEN_W     = 5;
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int IDX_W       = $clog2(MAX_THREADS);

  // Operation codes
  localparam logic [2:0] OP_PUT    = 3'd0;
  localparam logic [2:0] OP_GET    = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_BLOCK  = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic [ID_W-1:0]    thread_id;
    logic [TICKS_W-1:0] sleep_ticks;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    result_thread;
    logic [1:0]         status;
    logic [WOKEN_W-1:0] woken_count;
  } out_item_t;

  // Per-cycle command broadcast along a row of cells
  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_pos;
  } cell_ctl_t;

  // Zero counts as one; too wide saturates to the largest count
  function automatic logic [SLEEP_WIDTH-1:0] sat_ticks(input logic [TICKS_W-1:0] t);
    logic [TICKS_W-1:0]     t1;
    logic [SLEEP_WIDTH-1:0] r;
    t1 = (t == '0) ? TICKS_W'(1) : t;
    if ((64'(t1) >> SLEEP_WIDTH) != 64'd0) begin
      r = '1;
    end else begin
      r = SLEEP_WIDTH'(t1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/rqs_ready_cell.sv
module rqs_ready_cell import rqs_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  logic [ID_W-1:0]  wr_id,
  input  logic [ID_W-1:0]  nbr_id,
  output logic [ID_W-1:0]  id_q
);

  logic [ID_W-1:0] id_r, id_nxt;
  logic            hit;

  assign hit = ctl.wr_en && (ctl.wr_pos == idx);

  // Tail write wins over the shift from the right-hand neighbour
  always_comb begin
    id_nxt = id_r;
    if (hit) begin
      id_nxt = wr_id;
    end else if (ctl.shift) begin
      id_nxt = nbr_id;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign id_q = id_r;

endmodule

FILE: rtl/rqs_sleep_cell.sv
module rqs_sleep_cell import rqs_pkg::*; (
  input  logic                   clk,
  input  logic [IDX_W-1:0]       idx,
  input  cell_ctl_t              ctl,
  input  logic [ID_W-1:0]        wr_id,
  input  logic [SLEEP_WIDTH-1:0] wr_cnt,
  input  logic [ID_W-1:0]        nbr_id,
  input  logic [SLEEP_WIDTH-1:0] nbr_cnt,
  output logic [ID_W-1:0]        id_q,
  output logic [SLEEP_WIDTH-1:0] cnt_q
);

  logic [ID_W-1:0]        id_r, id_nxt;
  logic [SLEEP_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   hit;

  assign hit = ctl.wr_en && (ctl.wr_pos == idx);

  // Same move rules as a ready cell, carrying the countdown along
  always_comb begin
    id_nxt  = id_r;
    cnt_nxt = cnt_r;
    if (hit) begin
      id_nxt  = wr_id;
      cnt_nxt = wr_cnt;
    end else if (ctl.shift) begin
      id_nxt  = nbr_id;
      cnt_nxt = nbr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    cnt_r <= cnt_nxt;
  end

  assign id_q  = id_r;
  assign cnt_q = cnt_r;

endmodule

FILE: rtl/ready_queue_with_sleep_list.sv
// Channel | Ports                          | Item
// --------+--------------------------------+-------------------------------------------
// input   | in_valid, in_ready, in_item    | operation, thread_id, sleep_ticks
// output  | out_valid, out_ready, out_item | result_thread, status, woken_count
//
// Put, get, block and unused codes are answered straight from idle. Remove rotates the ready row once,
// visiting each ready entry; tick rotates the sleep row once, visiting each sleeper; an empty row
// is answered straight from idle. One item is in work at a time.
// Reset clears the counts and the sequencer; cell contents are left as they are.
// A result sits in the output register until taken; while the sequencer is idle, a new item is accepted
// in the cycle the result leaves, or whenever the register is empty.
module ready_queue_with_sleep_list import rqs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REMOVE = 2'd1;
  localparam logic [1:0] S_TICK   = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   rcount_r, rcount_nxt;
  logic [CNT_W-1:0]   scount_r, scount_nxt;
  logic [CNT_W-1:0]   iter_r, iter_nxt;
  logic               found_r, found_nxt;
  logic               full_hit_r, full_hit_nxt;
  logic [WOKEN_W-1:0] woken_r, woken_nxt;
  logic [ID_W-1:0]    rid_r, rid_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  cell_ctl_t              rctl, sctl;
  logic [ID_W-1:0]        r_wr_id, s_wr_id;
  logic [SLEEP_WIDTH-1:0] s_wr_cnt;

  logic [ID_W-1:0]        ready_q [MAX_THREADS];
  logic [ID_W-1:0]        sleep_id_q [MAX_THREADS];
  logic [SLEEP_WIDTH-1:0] sleep_cnt_q [MAX_THREADS];

  logic                   in_fire;
  logic                   drop;
  logic [SLEEP_WIDTH-1:0] dec_cnt;
  logic                   wake;
  logic                   ready_full;

  // Rows of cells, each shifting towards the head
  genvar g;
  generate
    for (g = 0; g < MAX_THREADS; g++) begin : g_cells
      logic [ID_W-1:0]        r_nbr, s_nbr;
      logic [SLEEP_WIDTH-1:0] c_nbr;
      if (g < MAX_THREADS - 1) begin : g_mid
        assign r_nbr = ready_q[g+1];
        assign s_nbr = sleep_id_q[g+1];
        assign c_nbr = sleep_cnt_q[g+1];
      end else begin : g_last
        assign r_nbr = '0;
        assign s_nbr = '0;
        assign c_nbr = '0;
      end
      rqs_ready_cell u_ready (
        .clk    (clk),
        .idx    (IDX_W'(g)),
        .ctl    (rctl),
        .wr_id  (r_wr_id),
        .nbr_id (r_nbr),
        .id_q   (ready_q[g])
      );
      rqs_sleep_cell u_sleep (
        .clk     (clk),
        .idx     (IDX_W'(g)),
        .ctl     (sctl),
        .wr_id   (s_wr_id),
        .wr_cnt  (s_wr_cnt),
        .nbr_id  (s_nbr),
        .nbr_cnt (c_nbr),
        .id_q    (sleep_id_q[g]),
        .cnt_q   (sleep_cnt_q[g])
      );
    end
  endgenerate

  assign in_ready   = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire    = in_valid && in_ready;
  assign ready_full = (rcount_r == CNT_W'(MAX_THREADS));

  // Head of each row during a rotation
  assign drop    = !found_r && (ready_q[0] == rid_r);
  assign dec_cnt = (sleep_cnt_q[0] > SLEEP_WIDTH'(1)) ? sleep_cnt_q[0] - SLEEP_WIDTH'(1)
                                                      : '0;
  assign wake    = (dec_cnt == '0) && !ready_full;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    rcount_nxt    = rcount_r;
    scount_nxt    = scount_r;
    iter_nxt      = iter_r;
    found_nxt     = found_r;
    full_hit_nxt  = full_hit_r;
    woken_nxt     = woken_r;
    rid_nxt       = rid_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rctl          = '0;
    sctl          = '0;
    r_wr_id       = in_item.thread_id;
    s_wr_id       = in_item.thread_id;
    s_wr_cnt      = sat_ticks(in_item.sleep_ticks);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_nxt       = '0;
          out_valid_nxt = 1'b1;
          unique case (in_item.operation)
            OP_PUT: begin
              if (ready_full) begin
                out_nxt.status = ST_FULL;
              end else begin
                rctl.wr_en  = 1'b1;
                rctl.wr_pos = IDX_W'(rcount_r);
                rcount_nxt  = rcount_r + CNT_W'(1);
              end
            end
            OP_GET: begin
              if (rcount_r == '0) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                out_nxt.result_thread = ready_q[0];
                rctl.shift = 1'b1;
                rcount_nxt = rcount_r - CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              if (rcount_r == '0) begin
                out_nxt.status = ST_NOT_FOUND;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_REMOVE;
                iter_nxt      = rcount_r;
                found_nxt     = 1'b0;
                rid_nxt       = in_item.thread_id;
              end
            end
            OP_BLOCK: begin
              if (scount_r == CNT_W'(MAX_THREADS)) begin
                out_nxt.status = ST_FULL;
              end else begin
                sctl.wr_en  = 1'b1;
                sctl.wr_pos = IDX_W'(scount_r);
                scount_nxt  = scount_r + CNT_W'(1);
              end
            end
            OP_TICK: begin
              if (scount_r != '0) begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_TICK;
                iter_nxt      = scount_r;
                woken_nxt     = '0;
                full_hit_nxt  = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Rotate the ready row once, dropping the first match
      S_REMOVE: begin
        rctl.shift = 1'b1;
        r_wr_id    = ready_q[0];
        if (drop) begin
          found_nxt  = 1'b1;
          rcount_nxt = rcount_r - CNT_W'(1);
        end else begin
          rctl.wr_en  = 1'b1;
          rctl.wr_pos = IDX_W'(rcount_r - CNT_W'(1));
        end
        iter_nxt = iter_r - CNT_W'(1);
        if (iter_r == CNT_W'(1)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.status = (found_r || drop) ? ST_OK : ST_NOT_FOUND;
        end
      end

      // Rotate the sleep row once; expired sleepers go to the ready tail while it has room
      S_TICK: begin
        sctl.shift = 1'b1;
        s_wr_id    = sleep_id_q[0];
        r_wr_id    = sleep_id_q[0];
        if (wake) begin
          rctl.wr_en  = 1'b1;
          rctl.wr_pos = IDX_W'(rcount_r);
          rcount_nxt  = rcount_r + CNT_W'(1);
          scount_nxt  = scount_r - CNT_W'(1);
          if (woken_r != '1) begin
            woken_nxt = woken_r + WOKEN_W'(1);
          end
        end else begin
          sctl.wr_en  = 1'b1;
          sctl.wr_pos = IDX_W'(scount_r - CNT_W'(1));
          if (dec_cnt == '0) begin
            s_wr_cnt     = SLEEP_WIDTH'(1);
            full_hit_nxt = 1'b1;
          end else begin
            s_wr_cnt = dec_cnt;
          end
        end
        iter_nxt = iter_r - CNT_W'(1);
        if (iter_r == CNT_W'(1)) begin
          state_nxt           = S_IDLE;
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.status      = (full_hit_r || (dec_cnt == '0 && !wake)) ? ST_FULL : ST_OK;
          out_nxt.woken_count = woken_nxt;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rcount_r    <= '0;
      scount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rcount_r    <= rcount_nxt;
      scount_r    <= scount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    iter_r     <= iter_nxt;
    found_r    <= found_nxt;
    full_hit_r <= full_hit_nxt;
    woken_r    <= woken_nxt;
    rid_r      <= rid_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: tb/sv/ready_queue_with_sleep_list_tb.sv
module ready_queue_with_sleep_list_tb import rqs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_OPS = 1830;
  localparam int PHASE_LEN  = 60;
  localparam int DRAIN_WAIT = 40;

  // Shaping of the random traffic
  localparam int MIX_FILL     = 0;
  localparam int MIX_DRAIN    = 1;
  localparam int MIX_BALANCED = 2;

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [SLEEP_WIDTH-1:0] remaining;
  } sleeper_t;

  // Shadow of the scheduler state plus the replies it still owes
  class sched_shadow;
    logic [ID_W-1:0] ready_q[$];
    sleeper_t        sleepers[$];
    out_item_t       owed_replies[$];
    int              errors;
    int              op_seen[8];
    int              status_seen[4];
    int              woken_total;

    function new();
      errors      = 0;
      woken_total = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Work out the reply for one operation and move the shadow state on
    function out_item_t apply_op(in_item_t it);
      out_item_t  r;
      sleeper_t   s;
      sleeper_t   kept[$];
      int         hit;
      int         woken;
      r   = '0;
      hit = -1;
      woken = 0;
      case (it.operation)
        OP_PUT: begin
          if (ready_q.size() >= MAX_THREADS) r.status = ST_FULL;
          else ready_q.push_back(it.thread_id);
        end
        OP_GET: begin
          if (ready_q.size() == 0) r.status = ST_EMPTY;
          else r.result_thread = ready_q.pop_front();
        end
        OP_REMOVE: begin
          foreach (ready_q[i]) begin
            if (hit < 0 && ready_q[i] == it.thread_id) hit = i;
          end
          if (hit < 0) r.status = ST_NOT_FOUND;
          else ready_q.delete(hit);
        end
        OP_BLOCK: begin
          if (sleepers.size() >= MAX_THREADS) begin
            r.status = ST_FULL;
          end else begin
            s.id        = it.thread_id;
            s.remaining = (it.sleep_ticks == '0) ? SLEEP_WIDTH'(1) : SLEEP_WIDTH'(it.sleep_ticks);
            sleepers.push_back(s);
          end
        end
        OP_TICK: begin
          // every sleeper counts down once; expired ones wake in list order
          foreach (sleepers[i]) begin
            s = sleepers[i];
            s.remaining = (s.remaining > 1) ? s.remaining - 1'b1 : '0;
            if (s.remaining == '0 && ready_q.size() < MAX_THREADS) begin
              ready_q.push_back(s.id);
              woken++;
            end else begin
              if (s.remaining == '0) begin
                // no room on the ready list: stays asleep, due next tick
                r.status    = ST_FULL;
                s.remaining = SLEEP_WIDTH'(1);
              end
              kept.push_back(s);
            end
          end
          sleepers      = kept;
          r.woken_count = (woken > 31) ? WOKEN_W'(31) : WOKEN_W'(woken);
          woken_total  += woken;
        end
        default: r = '0;
      endcase
      op_seen[it.operation]++;
      status_seen[r.status]++;
      return r;
    endfunction

    function void note_accepted(in_item_t it);
      owed_replies.push_back(apply_op(it));
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (owed_replies.size() == 0) begin
        $error("result item with no operation outstanding: %h", got);
        errors++;
      end else begin
        want = owed_replies.pop_front();
        if (got.result_thread !== want.result_thread) begin
          $error("result_thread: expected %0d, got %0d", want.result_thread, got.result_thread);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.woken_count !== want.woken_count) begin
          $error("woken_count: expected %0d, got %0d", want.woken_count, got.woken_count);
          errors++;
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int sender_idle_pct;
  int receiver_idle_pct;

  sched_shadow sb = new();

  ready_queue_with_sleep_list i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Both handshakes observed at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_accepted(in_item);
      if (out_valid && out_ready) sb.check_reply(out_item);
    end
  end

  // Receiver back-pressure, redrawn every cycle
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // Starts and ends at a falling edge
  task automatic send_op(input in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_item  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [2:0] op, input int id, input int ticks);
    in_item_t it;
    it.operation   = op;
    it.thread_id   = ID_W'(id);
    it.sleep_ticks = TICKS_W'(ticks);
    send_op(it);
  endtask

  function automatic logic [TICKS_W-1:0] pick_sleep();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 70) return TICKS_W'($urandom_range(3, 1));
    if (r < 99) return TICKS_W'($urandom_range(20, 4));
    return ($urandom_range(1) != 0) ? '1 : TICKS_W'($urandom);
  endfunction

  // One random operation; the mix can lean towards filling or draining the lists
  function automatic in_item_t pick_op(input int mix);
    in_item_t it;
    int       r;
    int       w_put, w_get, w_rem, w_blk;
    it.thread_id   = ID_W'($urandom);
    it.sleep_ticks = TICKS_W'($urandom);
    case (mix)
      MIX_FILL:  begin w_put = 45; w_get = 10; w_rem = 5;  w_blk = 28; end
      MIX_DRAIN: begin w_put = 6;  w_get = 38; w_rem = 20; w_blk = 6;  end
      default:   begin w_put = 24; w_get = 22; w_rem = 14; w_blk = 18; end
    endcase
    r = $urandom_range(99);
    if (r < 2) begin
      it.operation = OP_TICK + 3'($urandom_range(3, 1));
    end else if (r < 2 + w_put) begin
      it.operation = OP_PUT;
    end else if (r < 2 + w_put + w_get) begin
      it.operation = OP_GET;
    end else if (r < 2 + w_put + w_get + w_rem) begin
      it.operation = OP_REMOVE;
      if (sb.ready_q.size() != 0 && $urandom_range(99) < 75)
        it.thread_id = sb.ready_q[$urandom_range(sb.ready_q.size() - 1)];
    end else if (r < 2 + w_put + w_get + w_rem + w_blk) begin
      it.operation   = OP_BLOCK;
      it.sleep_ticks = pick_sleep();
    end else begin
      it.operation = OP_TICK;
    end
    return it;
  endfunction

  initial begin
    int mix;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_item           = '0;
    sender_idle_pct   = 30;
    receiver_idle_pct = 68;
    mix               = MIX_BALANCED;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty lists, duplicates, zero and maximum sleeps, unused codes
    send_fields(OP_GET,    0,  16'hffff);
    send_fields(OP_REMOVE, 3,  0);
    send_fields(OP_TICK,   0,  0);
    send_fields(OP_PUT,    0,  0);
    send_fields(OP_PUT,    15, 16'hffff);
    send_fields(OP_PUT,    15, 0);
    send_fields(OP_REMOVE, 15, 0);
    send_fields(OP_GET,    0,  0);
    send_fields(OP_GET,    0,  0);
    send_fields(OP_BLOCK,  9,  0);
    send_fields(OP_BLOCK,  6,  16'hffff);
    send_fields(OP_BLOCK,  10, 2);
    send_fields(OP_TICK,   0,  0);
    send_fields(OP_TICK,   0,  0);
    send_fields(OP_TICK + 3'd1, 15, 16'hffff);
    send_fields(OP_TICK + 3'd2, 5,  16'h5a5a);
    send_fields(OP_TICK + 3'd3, 10, 16'ha5a5);
    send_fields(OP_GET,    0,  0);
    send_fields(OP_GET,    0,  0);
    send_fields(OP_REMOVE, 6,  0);

    // Random: three idling regimes in turn
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == RANDOM_OPS / 3) begin
        sender_idle_pct   = 68;
        receiver_idle_pct = 30;
      end else if (n == 2 * RANDOM_OPS / 3) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      if (n % PHASE_LEN == 0) mix = $urandom_range(MIX_BALANCED);
      send_op(pick_op(mix));
    end
    in_valid = 1'b0;

    // Drain, then give the block time to show any stray result
    while (sb.owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ops: %0d put, %0d get, %0d remove, %0d block, %0d tick, %0d unused code",
             sb.op_seen[OP_PUT], sb.op_seen[OP_GET], sb.op_seen[OP_REMOVE],
             sb.op_seen[OP_BLOCK], sb.op_seen[OP_TICK],
             sb.op_seen[5] + sb.op_seen[6] + sb.op_seen[7]);
    $display("Outcomes: %0d empty, %0d full, %0d not found, %0d sleepers woken",
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL],
             sb.status_seen[ST_NOT_FOUND], sb.woken_total);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rqs_pkg.sv
rtl/rqs_ready_cell.sv
rtl/rqs_sleep_cell.sv
rtl/ready_queue_with_sleep_list.sv
tb/sv/ready_queue_with_sleep_list_tb.sv
